/* src/load_cell_adc_serial_reader_top_macros.svh */
// Assertion helpers used by the checker file lcsr_checker.sv.
`ifndef LOAD_CELL_ADC_SERIAL_READER_TOP_MACROS_SVH
`define LOAD_CELL_ADC_SERIAL_READER_TOP_MACROS_SVH

// Check out of reset only.
`define LCSR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define LCSR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lcsr_pkg.sv */
package lcsr_pkg;

  localparam int unsigned DATA_BITS_DEF = 24;
  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned HALF_W        = 16;
  localparam int unsigned GAIN_W        = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(1);
  localparam logic [HALF_W-1:0] HALF_RST     = HALF_W'(100);
  localparam logic [TIME_W-1:0] INTERVAL_RST = '0;
  localparam logic [TIME_W-1:0] CONV_RST     = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PULSES    = 2'd0,
    CFG_HALF_PERIOD    = 2'd1,
    CFG_FRAME_INTERVAL = 2'd2,
    CFG_CONVERSION     = 2'd3
  } lcsr_cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_pulses;
    logic [HALF_W-1:0] half_period_ticks;
    logic [TIME_W-1:0] frame_interval_ticks;
    logic [TIME_W-1:0] conversion_ticks;
  } lcsr_cfg_t;

  typedef struct packed {
    logic              kind;
    logic              data_level;
    logic [TIME_W-1:0] now_time;
  } lcsr_item_t;

  typedef struct packed {
    logic                       clock_level;
    logic [TIME_W-1:0]          wake_at;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample_value;
  } lcsr_result_t;

endpackage

/* src/lcsr_cfg.sv */
module lcsr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output lcsr_pkg::lcsr_cfg_t                cfg_o
);
  import lcsr_pkg::*;

  lcsr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_pulses          <= GAIN_RST;
      cfg_q.half_period_ticks    <= HALF_RST;
      cfg_q.frame_interval_ticks <= INTERVAL_RST;
      cfg_q.conversion_ticks     <= CONV_RST;
    end else if (cfg_we_i) begin
      case (lcsr_cfg_idx_e'(cfg_index_i))
        CFG_GAIN_PULSES:    cfg_q.gain_pulses          <= cfg_data_i[GAIN_W-1:0];
        CFG_HALF_PERIOD:    cfg_q.half_period_ticks    <= cfg_data_i[HALF_W-1:0];
        CFG_FRAME_INTERVAL: cfg_q.frame_interval_ticks <= cfg_data_i[TIME_W-1:0];
        CFG_CONVERSION:     cfg_q.conversion_ticks     <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/lcsr_core.sv */
module lcsr_core #(
  parameter int unsigned DATA_BITS = lcsr_pkg::DATA_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  lcsr_pkg::lcsr_item_t   item_i,
  input  lcsr_pkg::lcsr_cfg_t    cfg_i,
  output lcsr_pkg::lcsr_result_t result_o
);
  import lcsr_pkg::*;

  // Counter holds up to 2*DATA_BITS + 6.
  localparam int unsigned HC_W = $clog2(2 * DATA_BITS + 7);
  localparam logic [HC_W-1:0] DATA_HALVES = HC_W'(2 * DATA_BITS);

  logic [HC_W-1:0]      half_count_q, half_count_d, half_count_step;
  logic [DATA_BITS-1:0] shift_q, shift_d, shift_step;
  logic [TIME_W-1:0]    wake_q, wake_d;
  logic                 clock_q, clock_d;

  logic                 not_ready;
  logic                 drive;
  logic                 frame_done;
  logic [HC_W-1:0]      end_cnt;
  logic [HALF_W:0]      step_ticks;
  logic [TIME_W-1:0]    add_a, add_b, add_c;
  logic [SAMPLE_W+DATA_BITS-1:0] sample_ext;

  assign end_cnt   = DATA_HALVES + HC_W'({cfg_i.gain_pulses, 1'b0});
  assign not_ready = (half_count_q == '0) && item_i.data_level;

  // One half period of the serial clock.
  always_comb begin
    half_count_step = half_count_q;
    shift_step      = shift_q;
    drive           = 1'b0;
    step_ticks      = {1'b0, cfg_i.half_period_ticks};
    if (not_ready) begin
      step_ticks = {cfg_i.half_period_ticks, 1'b0};
    end else if (half_count_q[0]) begin
      if (half_count_q < DATA_HALVES) begin
        shift_step = {shift_q[DATA_BITS-2:0], item_i.data_level};
      end
      half_count_step = half_count_q + HC_W'(1);
    end else begin
      drive           = 1'b1;
      half_count_step = half_count_q + HC_W'(1);
    end
  end

  assign frame_done = half_count_step >= end_cnt;

  // Single three-input add serves both item kinds.
  assign add_a  = item_i.kind ? wake_q : item_i.now_time;
  assign add_b  = item_i.kind ? TIME_W'(step_ticks) : cfg_i.conversion_ticks;
  assign add_c  = (item_i.kind && frame_done) ? cfg_i.frame_interval_ticks : '0;
  assign wake_d = add_a + add_b + add_c;

  assign sample_ext = {{SAMPLE_W{shift_step[DATA_BITS-1]}}, shift_step};

  always_comb begin
    half_count_d = half_count_q;
    shift_d      = shift_q;
    clock_d      = clock_q;
    if (item_i.kind) begin
      half_count_d = frame_done ? '0 : half_count_step;
      shift_d      = frame_done ? '0 : shift_step;
      clock_d      = drive && !frame_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_count_q <= '0;
      shift_q      <= '0;
      wake_q       <= '0;
      clock_q      <= 1'b0;
    end else if (step_i) begin
      half_count_q <= half_count_d;
      shift_q      <= shift_d;
      wake_q       <= wake_d;
      clock_q      <= clock_d;
    end
  end

  assign result_o.clock_level  = clock_d;
  assign result_o.wake_at      = wake_d;
  assign result_o.sample_valid = item_i.kind && frame_done;
  assign result_o.sample_value = (item_i.kind && frame_done) ?
                                 sample_ext[SAMPLE_W-1:0] : '0;

endmodule

/* src/load_cell_adc_serial_reader_top.sv */
// Pipeline: an accepted item waits in the input register, then moves into the
//   result register, which offers its result until the result side takes it.
// Throughput: one item per cycle unless the result side stalls; the state
//   update is one compare, shift and three-input add between the two registers.
// Reset (rst_ni low, asynchronous): both pipeline registers empty, counter,
//   shift register, wake time and clock level cleared, registers to defaults.
module load_cell_adc_serial_reader_top #(
  parameter int unsigned DATA_BITS = lcsr_pkg::DATA_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // item input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  kind_i,
  input  logic                                  data_level_i,
  input  logic [lcsr_pkg::TIME_W-1:0]           now_time_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  clock_level_o,
  output logic [lcsr_pkg::TIME_W-1:0]           wake_at_o,
  output logic                                  sample_valid_o,
  output logic signed [lcsr_pkg::SAMPLE_W-1:0]  sample_value_o,
  // register write port
  input  logic                                  cfg_we_i,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import lcsr_pkg::*;

  lcsr_cfg_t    cfg;
  lcsr_item_t   item_q;
  logic         in_vld_q;
  lcsr_result_t res_d, res_q;
  logic         out_vld_q;
  logic         advance;

  lcsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held item into the result register whenever that register is
  // empty or being drained this cycle.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  // Hold off the sender only when the input register is full and stuck.
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Item payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.kind       <= kind_i;
      item_q.data_level <= data_level_i;
      item_q.now_time   <= now_time_i;
    end
  end

  // Frame state lives in the core and updates on the cycle the item advances,
  // so the following item already sees it.
  lcsr_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign clock_level_o  = res_q.clock_level;
  assign wake_at_o      = res_q.wake_at;
  assign sample_valid_o = res_q.sample_valid;
  assign sample_value_o = res_q.sample_value;

endmodule

/* src/lcsr_checker.sv */
`include "load_cell_adc_serial_reader_top_macros.svh"

module lcsr_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 clock_level_o,
  input logic [lcsr_pkg::TIME_W-1:0]          wake_at_o,
  input logic                                 sample_valid_o,
  input logic signed [lcsr_pkg::SAMPLE_W-1:0] sample_value_o
);

  `LCSR_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result during reset")

  `LCSR_ASSERT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  `LCSR_ASSERT(a_out_payload_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(wake_at_o) && $stable(sample_value_o), "stalled result changed")

  `LCSR_ASSERT(a_frame_end_clock_low, clk_i, rst_ni, out_valid_o && sample_valid_o |-> !clock_level_o, "clock left high at frame end")

  `LCSR_ASSERT(a_idle_sample_zero, clk_i, rst_ni, out_valid_o && !sample_valid_o |-> sample_value_o == '0, "sample value without sample")

endmodule

bind load_cell_adc_serial_reader_top lcsr_checker u_lcsr_checker (.*);

/* tb/sv/lcsr_tb_pkg.sv */
`timescale 1ns / 1ps

package lcsr_tb_pkg;

  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_TICK  = 1'b1
  } lcsr_kind_e;

endpackage

/* tb/sv/load_cell_adc_serial_reader_checker.sv */
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_checker #(
  parameter int unsigned DATA_BITS = lcsr_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic                                 kind_i,
  input  logic                                 data_level_i,
  input  logic [lcsr_pkg::TIME_W-1:0]          now_time_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic                                 clock_level_i,
  input  logic [lcsr_pkg::TIME_W-1:0]          wake_at_i,
  input  logic                                 sample_valid_i,
  input  logic signed [lcsr_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                                 cfg_we_i,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output int                                   error_count_o,
  output int                                   pending_o
);
  import lcsr_pkg::*;
  import lcsr_tb_pkg::*;

  logic [GAIN_W-1:0] gain_pulses;
  logic [HALF_W-1:0] half_ticks;
  logic [TIME_W-1:0] interval_ticks;
  logic [TIME_W-1:0] conv_ticks;

  int unsigned          half_count;
  logic [DATA_BITS-1:0] shift_bits;
  logic [TIME_W-1:0]    wake_time;
  logic                 clock_level;

  lcsr_result_t readings_q[$];
  int           mismatch_count = 0;

  assign error_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the reader by one item and return the reading it should produce.
  function automatic lcsr_result_t step_reader(input lcsr_item_t it);
    lcsr_result_t r;
    logic         drive;
    int unsigned  end_count;
    logic [63:0]  ext;
    r     = '0;
    drive = 1'b0;
    if (it.kind == ITEM_START) begin
      wake_time = it.now_time + conv_ticks;
    end else begin
      end_count = 2 * DATA_BITS + 2 * gain_pulses;
      if (half_count == 0 && it.data_level) begin
        // converter not ready: wait a full clock period
        wake_time = wake_time + {half_ticks, 1'b0};
      end else begin
        if (half_count % 2 == 1) begin
          if (half_count < 2 * DATA_BITS) begin
            shift_bits = {shift_bits[DATA_BITS-2:0], it.data_level};
          end
        end else begin
          drive = 1'b1;
        end
        half_count++;
        wake_time = wake_time + half_ticks;
      end
      if (half_count >= end_count) begin
        ext = {{(64-DATA_BITS){shift_bits[DATA_BITS-1]}}, shift_bits};
        r.sample_valid = 1'b1;
        r.sample_value = ext[SAMPLE_W-1:0];
        wake_time      = wake_time + interval_ticks;
        half_count     = 0;
        shift_bits     = '0;
        drive          = 1'b0;
      end
      clock_level = drive;
    end
    r.clock_level = clock_level;
    r.wake_at     = wake_time;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lcsr_result_t want;
    lcsr_item_t   it;
    if (!rst_ni) begin
      gain_pulses    = GAIN_RST;
      half_ticks     = HALF_RST;
      interval_ticks = INTERVAL_RST;
      conv_ticks     = CONV_RST;
      half_count     = 0;
      shift_bits     = '0;
      wake_time      = '0;
      clock_level    = 1'b0;
      readings_q.delete();
      pending_o <= 0;
    end else begin
      // Results first: a result never belongs to an item accepted at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (readings_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending, wake_at %0h", wake_at_i));
        end else begin
          want = readings_q.pop_front();
          if (clock_level_i !== want.clock_level)
            report_mismatch($sformatf("clock_level %0b, expected %0b",
                                      clock_level_i, want.clock_level));
          if (wake_at_i !== want.wake_at)
            report_mismatch($sformatf("wake_at %0h, expected %0h", wake_at_i, want.wake_at));
          if (sample_valid_i !== want.sample_valid)
            report_mismatch($sformatf("sample_valid %0b, expected %0b",
                                      sample_valid_i, want.sample_valid));
          if (sample_value_i !== want.sample_value)
            report_mismatch($sformatf("sample_value %0h, expected %0h",
                                      sample_value_i, want.sample_value));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN_PULSES:    gain_pulses    = cfg_data_i[GAIN_W-1:0];
          CFG_HALF_PERIOD:    half_ticks     = cfg_data_i[HALF_W-1:0];
          CFG_FRAME_INTERVAL: interval_ticks = cfg_data_i;
          CFG_CONVERSION:     conv_ticks     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        it = '{kind: kind_i, data_level: data_level_i, now_time: now_time_i};
        readings_q.push_back(step_reader(it));
      end
      pending_o <= readings_q.size();
    end
  end

endmodule

/* tb/sv/tb_load_cell_adc_serial_reader_top.sv */
`timescale 1ns / 1ps

module tb_load_cell_adc_serial_reader_top;
  import lcsr_pkg::*;
  import lcsr_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 1300;
  // Data bits end at this half-period count; gain pulses follow.
  localparam int unsigned DATA_HALVES = 2 * DATA_BITS_DEF;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic                        kind_i       = 1'b0;
  logic                        data_level_i = 1'b0;
  logic [TIME_W-1:0]           now_time_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic                        clock_level_o;
  logic [TIME_W-1:0]           wake_at_o;
  logic                        sample_valid_o;
  logic signed [SAMPLE_W-1:0]  sample_value_o;
  logic                        cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i   = '0;

  int mismatches;
  int pending_readings;

  // Idle bounds for the two sides; a phase sets them to 0 for stretches
  // of back-to-back traffic.
  int unsigned in_idle_max  = 8;
  int unsigned out_idle_max = 8;

  // Rough mirror of the half-period counter, used only to shape frames.
  int unsigned    frame_pos = 0;
  logic [GAIN_W-1:0] gain_now = GAIN_RST;
  int unsigned    items_sent = 0;

  always #5 clk_i = ~clk_i;

  load_cell_adc_serial_reader_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_level_i   (data_level_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .clock_level_o  (clock_level_o),
    .wake_at_o      (wake_at_o),
    .sample_valid_o (sample_valid_o),
    .sample_value_o (sample_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  load_cell_adc_serial_reader_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .data_level_i   (data_level_i),
    .now_time_i     (now_time_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .clock_level_i  (clock_level_o),
    .wake_at_i      (wake_at_o),
    .sample_valid_i (sample_valid_o),
    .sample_value_i (sample_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (mismatches),
    .pending_o      (pending_readings)
  );

  // Offer one item after a random gap and hold it until accepted. Valid stays
  // high on return, so a zero-gap follower goes out back to back.
  task automatic send_item(input lcsr_kind_e kind, input logic level,
                           input logic [TIME_W-1:0] now);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    data_level_i <= level;
    now_time_i   <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    // Track the frame position so frames can be laid out bit by bit.
    if (kind == ITEM_TICK && !(frame_pos == 0 && level)) begin
      frame_pos++;
      if (frame_pos >= DATA_HALVES + 2 * gain_now) frame_pos = 0;
    end
  endtask

  // Run ticks through one frame carrying the given sample, MSB first on the
  // odd half periods. A nonzero cut abandons the frame after that many ticks.
  task automatic send_frame(input logic [SAMPLE_W-1:0] sample, input int unsigned cut);
    int unsigned ticks;
    logic        level;
    ticks = 0;
    // Converter not ready for a few wakes before the frame.
    if (frame_pos == 0) begin
      repeat ($urandom_range(0, 3)) send_item(ITEM_TICK, 1'b1, $urandom);
    end
    do begin
      if (frame_pos == 0) begin
        level = 1'b0;
      end else if (frame_pos % 2 == 1 && frame_pos < DATA_HALVES) begin
        level = sample[SAMPLE_W - 1 - (frame_pos - 1) / 2];
      end else begin
        level = 1'($urandom_range(0, 1));
      end
      // Now and then a start request lands mid-frame; it must not restart it.
      if ($urandom_range(0, 39) == 0)
        send_item(ITEM_START, 1'($urandom_range(0, 1)), $urandom);
      send_item(ITEM_TICK, level, $urandom);
      ticks++;
    end while (frame_pos != 0 && !(cut != 0 && ticks >= cut));
  endtask

  task automatic write_reg(input lcsr_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_GAIN_PULSES) gain_now = data[GAIN_W-1:0];
  endtask

  // Drop valid and wait until every reading is back, then let the pipe empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 500);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_half();
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return 32'h0000_FFFF;
      2:       return $urandom_range(1, 20);
      default: return $urandom;
    endcase
  endfunction

  // Result side: stall a random number of cycles before each result.
  initial begin
    int unsigned n;
    @(posedge clk_i);
    forever begin
      n = $urandom_range(0, out_idle_max);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned cut;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults first, then every register at an extreme.
    send_item(ITEM_TICK, 1'b1, '0);
    send_item(ITEM_START, 1'b0, 32'h1234_5678);
    settle();
    write_reg(CFG_CONVERSION, '1);
    write_reg(CFG_HALF_PERIOD, 32'h0000_FFFF);
    write_reg(CFG_FRAME_INTERVAL, '1);
    write_reg(CFG_GAIN_PULSES, '0);
    // Wake arithmetic wraps on both start and tick.
    send_item(ITEM_START, 1'b1, '0);
    send_item(ITEM_START, 1'b0, '1);
    send_item(ITEM_TICK, 1'b1, '1);
    // Frame opens, sign bit set, then a start inside the frame.
    send_item(ITEM_TICK, 1'b0, '0);
    send_item(ITEM_TICK, 1'b1, $urandom);
    send_item(ITEM_START, 1'b0, $urandom);
    send_item(ITEM_TICK, 1'b0, $urandom);
    send_item(ITEM_TICK, 1'b0, $urandom);

    // Random phases: well-formed frames with random content, some broken
    // frames and loose noise, with a register change between phases.
    while (items_sent < ITEM_TARGET) begin
      settle();
      if ($urandom_range(0, 1)) write_reg(CFG_GAIN_PULSES, $urandom);
      if ($urandom_range(0, 1)) write_reg(CFG_HALF_PERIOD, pick_half());
      if ($urandom_range(0, 1)) write_reg(CFG_FRAME_INTERVAL, pick_time());
      if ($urandom_range(0, 1)) write_reg(CFG_CONVERSION, pick_time());
      case ($urandom_range(0, 3))
        0:       begin in_idle_max = 0; out_idle_max = 0; end
        1:       begin in_idle_max = 0; out_idle_max = 8; end
        2:       begin in_idle_max = 8; out_idle_max = 0; end
        default: begin in_idle_max = 8; out_idle_max = 8; end
      endcase
      if ($urandom_range(0, 1))
        send_item(ITEM_START, 1'($urandom_range(0, 1)), $urandom);
      repeat ($urandom_range(1, 3)) send_frame(pick_sample(), 0);
      // Broken frame: often cut near the end so a gain change can land past
      // the new end count.
      if ($urandom_range(0, 2) == 0) begin
        cut = $urandom_range(0, 1) ? $urandom_range(46, 53) : $urandom_range(1, 45);
        send_frame(pick_sample(), cut);
      end
      repeat ($urandom_range(0, 4)) begin
        send_item($urandom_range(0, 1) ? ITEM_TICK : ITEM_START,
                  1'($urandom_range(0, 1)), $urandom);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop: a run that has not finished by this time counts as an error.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/lcsr_pkg.sv
src/lcsr_cfg.sv
src/lcsr_core.sv
src/load_cell_adc_serial_reader_top.sv
src/lcsr_checker.sv
tb/sv/lcsr_tb_pkg.sv
tb/sv/load_cell_adc_serial_reader_checker.sv
tb/sv/tb_load_cell_adc_serial_reader_top.sv
